/* rtl/lr_pkg.sv */
// Shared types and constants for the line rasterizer.
package lr_pkg;

  // Default coordinate width and fixed color width
  localparam int COORD_BITS_DEF = 10;
  localparam int COLOR_BITS     = 24;

  // Reset value of the foreground color register
  localparam logic [COLOR_BITS-1:0] FG_COLOR_RST = 24'hFF_FFFF;

  // Item kinds carried on the input tuser bit
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  // Per-axis walk direction
  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_PLUS  = 2'd1,
    DIR_MINUS = 2'd2
  } dir_t;

endpackage

/* rtl/line_rasterizer.sv */
// Line rasterizer: endpoint load and one-pixel-per-step error-term walk.
//
//   Channel  | Direction | Signals                        | Carries
//   s_axis   | in        | tvalid tready tdata tuser      | load / step item
//   m_axis   | out       | tvalid tready tdata tlast      | one pixel item
//   cfg      | in        | cfg_wr_en cfg_wr_data          | foreground color
//
// One input item is taken per clock; a step item with a line in progress
// yields its pixel in the output register in the next cycle. The walk state is
// updated in the accepting cycle by one add, one compare and one subtract per
// axis, so the error-term adders set the cycle time. Input is stalled only
// while the output register holds a pixel that the sink does not take.
// Synchronous reset leaves the block idle with the color set to white.
module line_rasterizer #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  // Input items
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata: x_start, y_start, x_stop, y_stop (lowest bit up), zero padded
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // tuser: mode
  input  logic s_axis_tuser,
  // Pixel items
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // tdata: pixel_x, pixel_y, pixel_color (lowest bit up), zero padded
  output logic [((2*COORD_BITS+lr_pkg::COLOR_BITS+7)/8)*8-1:0] m_axis_tdata,
  // tlast: last_pixel
  output logic m_axis_tlast,
  // Foreground color register
  input  logic cfg_wr_en,
  input  logic [lr_pkg::COLOR_BITS-1:0] cfg_wr_data
);

  localparam int CW     = COORD_BITS;
  localparam int OUT_W  = 2*CW + lr_pkg::COLOR_BITS;
  localparam int OUT_TW = ((OUT_W+7)/8)*8;

  // Foreground color
  logic [lr_pkg::COLOR_BITS-1:0] fg_color;

  // Walk state
  logic                busy, busy_next;
  logic                flat_mode, flat_mode_next;
  logic [CW-1:0]       cur_col, cur_col_next;
  logic [CW-1:0]       cur_row, cur_row_next;
  logic [CW-1:0]       col_err, col_err_next;
  logic [CW-1:0]       row_err, row_err_next;
  logic [CW-1:0]       col_delta, col_delta_next;
  logic [CW-1:0]       row_delta, row_delta_next;
  lr_pkg::dir_t        col_dir, col_dir_next;
  lr_pkg::dir_t        row_dir, row_dir_next;
  logic [CW-1:0]       major_len, major_len_next;
  logic [CW:0]         steps_left, steps_left_next;

  // Output register
  logic                out_valid;
  logic [CW-1:0]       out_x, out_y;
  logic [lr_pkg::COLOR_BITS-1:0] out_color;
  logic                out_last;

  // Input unpacking
  logic          in_accept;
  logic          emit;
  logic [CW-1:0] x1, y1, x2, y2;
  logic [CW:0]   col_sum, row_sum;

  assign x1 = s_axis_tdata[CW-1:0];
  assign y1 = s_axis_tdata[2*CW-1:CW];
  assign x2 = s_axis_tdata[3*CW-1:2*CW];
  assign y2 = s_axis_tdata[4*CW-1:3*CW];

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign emit          = in_accept && (s_axis_tuser == lr_pkg::MODE_STEP) && busy;

  // Move one unit along an axis, wrapping at the coordinate width
  function automatic logic [CW-1:0] axis_move(input logic [CW-1:0] pos,
                                               input lr_pkg::dir_t dir);
    logic [CW-1:0] res;
    unique case (dir)
      lr_pkg::DIR_PLUS:  res = pos + CW'(1);
      lr_pkg::DIR_MINUS: res = pos - CW'(1);
      default:           res = pos;
    endcase
    return res;
  endfunction

  // Compute the next walk state for a load or a step
  always_comb begin
    busy_next       = busy;
    flat_mode_next  = flat_mode;
    cur_col_next    = cur_col;
    cur_row_next    = cur_row;
    col_err_next    = col_err;
    row_err_next    = row_err;
    col_delta_next  = col_delta;
    row_delta_next  = row_delta;
    col_dir_next    = col_dir;
    row_dir_next    = row_dir;
    major_len_next  = major_len;
    steps_left_next = steps_left;
    col_sum         = {1'b0, col_err} + {1'b0, col_delta};
    row_sum         = {1'b0, row_err} + {1'b0, row_delta};

    if (in_accept && s_axis_tuser == lr_pkg::MODE_LOAD) begin
      cur_col_next = x1;
      cur_row_next = y1;
      col_err_next = '0;
      row_err_next = '0;
      // Column delta and direction
      priority if (x2 > x1) begin
        col_delta_next = x2 - x1;
        col_dir_next   = lr_pkg::DIR_PLUS;
      end else if (x2 < x1) begin
        col_delta_next = x1 - x2;
        col_dir_next   = lr_pkg::DIR_MINUS;
      end else begin
        col_delta_next = '0;
        col_dir_next   = lr_pkg::DIR_NONE;
      end
      // Row delta and direction
      priority if (y2 > y1) begin
        row_delta_next = y2 - y1;
        row_dir_next   = lr_pkg::DIR_PLUS;
      end else if (y2 < y1) begin
        row_delta_next = y1 - y2;
        row_dir_next   = lr_pkg::DIR_MINUS;
      end else begin
        row_delta_next = '0;
        row_dir_next   = lr_pkg::DIR_NONE;
      end
      major_len_next = (col_delta_next > row_delta_next) ? col_delta_next : row_delta_next;
      // Flat lines emit the half-open column range only
      if (y1 == y2) begin
        flat_mode_next  = 1'b1;
        steps_left_next = (x2 > x1) ? {1'b0, x2 - x1} : '0;
      end else begin
        flat_mode_next  = 1'b0;
        steps_left_next = {1'b0, major_len_next} + (CW+1)'(2);
      end
      busy_next = (steps_left_next != '0);
    end else if (emit) begin
      if (flat_mode) begin
        cur_col_next = cur_col + CW'(1);
      end else begin
        // Advance each axis whose error sum passes the major distance
        if (col_sum > {1'b0, major_len}) begin
          col_err_next = CW'(col_sum - {1'b0, major_len});
          cur_col_next = axis_move(cur_col, col_dir);
        end else begin
          col_err_next = col_sum[CW-1:0];
        end
        if (row_sum > {1'b0, major_len}) begin
          row_err_next = CW'(row_sum - {1'b0, major_len});
          cur_row_next = axis_move(cur_row, row_dir);
        end else begin
          row_err_next = row_sum[CW-1:0];
        end
      end
      steps_left_next = steps_left - (CW+1)'(1);
      busy_next       = (steps_left_next != '0);
    end
  end

  // Hold control state and walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      flat_mode  <= 1'b0;
      steps_left <= '0;
      fg_color   <= lr_pkg::FG_COLOR_RST;
    end else begin
      busy       <= busy_next;
      flat_mode  <= flat_mode_next;
      steps_left <= steps_left_next;
      if (cfg_wr_en) begin
        fg_color <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_col   <= cur_col_next;
    cur_row   <= cur_row_next;
    col_err   <= col_err_next;
    row_err   <= row_err_next;
    col_delta <= col_delta_next;
    row_delta <= row_delta_next;
    col_dir   <= col_dir_next;
    row_dir   <= row_dir_next;
    major_len <= major_len_next;
  end

  // Load the output register on a step; drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_x     <= cur_col;
      out_y     <= cur_row;
      out_color <= fg_color;
      out_last  <= (steps_left == (CW+1)'(1));
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TW'({out_color, out_y, out_x});
  assign m_axis_tlast  = out_last;

`ifndef SYNTHESIS
  // A line in progress always has pixels left
  a_busy_steps : assert property (@(posedge clk) disable iff (rst)
    busy |-> steps_left != '0)
    else $error("busy with no steps left");

  // Error terms stay within the major distance on a sloped walk
  a_err_bound : assert property (@(posedge clk) disable iff (rst)
    (busy && !flat_mode) |-> (col_err <= major_len && row_err <= major_len))
    else $error("error term past major distance");

  // The last pixel ends the line
  a_last_idle : assert property (@(posedge clk) disable iff (rst)
    (emit && steps_left == (CW+1)'(1)) |=> !busy)
    else $error("line continues after last pixel");

  // Input stalls only behind a held pixel
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without held pixel");
`endif

endmodule

/* dv/tb.sv */
// Self-checking testbench for line_rasterizer: directed table, then random lines under idling.
module tb;

  localparam int CB     = lr_pkg::COORD_BITS_DEF;
  localparam int CLR_W  = lr_pkg::COLOR_BITS;
  localparam int IN_W   = ((4*CB+7)/8)*8;
  localparam int OUT_W  = ((2*CB+CLR_W+7)/8)*8;

  // Short names for the item kinds in the directed table
  localparam logic LD = lr_pkg::MODE_LOAD;
  localparam logic ST = lr_pkg::MODE_STEP;

  typedef logic [CB-1:0] coord_t;

  typedef struct packed {
    coord_t                 x;
    coord_t                 y;
    logic [CLR_W-1:0]       color;
    logic                   last;
  } pixel_t;

  // How a directed row is checked
  typedef enum logic [1:0] {
    EXP_MODEL,
    EXP_PIXEL,
    EXP_NONE
  } exp_t;

  typedef struct packed {
    logic   mode;
    coord_t xa;
    coord_t ya;
    coord_t xb;
    coord_t yb;
    exp_t   chk;
    coord_t ex;
    coord_t ey;
    logic   elast;
  } row_t;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata;
  logic s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_wr_en;
  logic [CLR_W-1:0] cfg_wr_data;

  line_rasterizer #(.COORD_BITS(CB)) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  // Walk state of the line predictor
  logic                  w_busy;
  logic                  w_flat;
  coord_t                w_col, w_row;
  coord_t                w_col_err, w_row_err;
  coord_t                w_col_d, w_row_d;
  lr_pkg::dir_t          w_col_dir, w_row_dir;
  coord_t                w_major;
  logic [CB:0]           w_left;
  logic [CLR_W-1:0]      w_color;

  pixel_t pending_pixels[$];
  int     mismatch_cnt;
  int     taken_items;
  int     send_idle_pct;
  int     recv_stall_pct;
  row_t   plan [25];

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Absolute distance and direction along one axis
  function automatic void setup_axis(input coord_t a, input coord_t b,
                                     output coord_t d, output lr_pkg::dir_t dir);
    if (b > a) begin
      d   = b - a;
      dir = lr_pkg::DIR_PLUS;
    end else if (b < a) begin
      d   = a - b;
      dir = lr_pkg::DIR_MINUS;
    end else begin
      d   = '0;
      dir = lr_pkg::DIR_NONE;
    end
  endfunction

  function automatic coord_t move_axis(input coord_t pos, input lr_pkg::dir_t dir);
    if (dir == lr_pkg::DIR_PLUS) return pos + 1'b1;
    if (dir == lr_pkg::DIR_MINUS) return pos - 1'b1;
    return pos;
  endfunction

  // Predict one item: load latches the line, step yields the current pixel
  function automatic bit rasterize_item(input logic mode, input coord_t xa, ya, xb, yb,
                                        output pixel_t px);
    logic [CB:0] col_sum;
    logic [CB:0] row_sum;
    px = '0;
    if (mode == lr_pkg::MODE_LOAD) begin
      w_col     = xa;
      w_row     = ya;
      w_col_err = '0;
      w_row_err = '0;
      setup_axis(xa, xb, w_col_d, w_col_dir);
      setup_axis(ya, yb, w_row_d, w_row_dir);
      w_major = (w_col_d > w_row_d) ? w_col_d : w_row_d;
      if (ya == yb) begin
        w_flat = 1'b1;
        w_left = (xb > xa) ? {1'b0, coord_t'(xb - xa)} : '0;
      end else begin
        w_flat = 1'b0;
        w_left = {1'b0, w_major} + 2'd2;
      end
      w_busy = (w_left != 0);
      return 1'b0;
    end
    if (!w_busy) return 1'b0;
    px.x     = w_col;
    px.y     = w_row;
    px.color = w_color;
    px.last  = (w_left == 1);
    if (w_flat) begin
      w_col = w_col + 1'b1;
    end else begin
      col_sum = {1'b0, w_col_err} + {1'b0, w_col_d};
      row_sum = {1'b0, w_row_err} + {1'b0, w_row_d};
      if (col_sum > {1'b0, w_major}) begin
        col_sum = col_sum - {1'b0, w_major};
        w_col   = move_axis(w_col, w_col_dir);
      end
      if (row_sum > {1'b0, w_major}) begin
        row_sum = row_sum - {1'b0, w_major};
        w_row   = move_axis(w_row, w_row_dir);
      end
      w_col_err = col_sum[CB-1:0];
      w_row_err = row_sum[CB-1:0];
    end
    w_left = w_left - 1'b1;
    if (w_left == 0) w_busy = 1'b0;
    return 1'b1;
  endfunction

  // Offer one item after a random gap; queue its pixel once accepted
  task automatic send_item(input logic mode, input coord_t xa, ya, xb, yb,
                           input exp_t chk, input pixel_t typed);
    pixel_t px;
    bit     got;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {yb, xb, ya, xa};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    got = rasterize_item(mode, xa, ya, xb, yb, px);
    if (chk == EXP_PIXEL) begin
      typed.color = w_color;
      pending_pixels.push_back(typed);
    end else if (chk == EXP_MODEL && got) begin
      pending_pixels.push_back(px);
    end
    if (mode == lr_pkg::MODE_LOAD || got) taken_items++;
    @(negedge clk);
  endtask

  // Hold input and let every queued pixel come out
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_color(input logic [CLR_W-1:0] c);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= c;
    w_color      = c;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic coord_t pick_coord();
    if ($urandom_range(4) == 0)
      return $urandom_range(1) ? coord_t'($urandom_range(3))
                               : coord_t'(1020 + $urandom_range(3));
    return coord_t'($urandom);
  endfunction

  // Random lines: mostly complete walks, some cut short or overrun, some noise
  task automatic run_lines(input int target);
    int     first;
    int     kind;
    int     dx, dy, n, r;
    coord_t xa, ya, xb, yb;
    pixel_t no_px;
    first = taken_items;
    no_px = '0;
    while (taken_items - first < target) begin
      kind = $urandom_range(99);
      if (kind < 12) begin
        send_item(1'($urandom_range(1)), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), coord_t'($urandom), EXP_MODEL, no_px);
        continue;
      end
      xa = pick_coord();
      ya = pick_coord();
      if (kind < 17) begin
        xb = coord_t'($urandom);
        yb = coord_t'($urandom);
      end else begin
        if (kind < 30) begin
          dx = int'($urandom_range(128)) - 64;
          dy = int'($urandom_range(128)) - 64;
        end else begin
          dx = int'($urandom_range(12)) - 6;
          dy = int'($urandom_range(12)) - 6;
        end
        if ($urandom_range(9) == 0) dy = 0;
        xb = xa + dx[CB-1:0];
        yb = ya + dy[CB-1:0];
      end
      send_item(lr_pkg::MODE_LOAD, xa, ya, xb, yb, EXP_MODEL, no_px);
      n = int'(w_left);
      r = $urandom_range(99);
      if (r < 15) n = $urandom_range(n);
      else if (r < 30) n = n + $urandom_range(1, 3);
      if (kind < 17 && n > 40) n = $urandom_range(40);
      repeat (n) begin
        send_item(lr_pkg::MODE_STEP, coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), coord_t'($urandom), EXP_MODEL, no_px);
      end
    end
  endtask

  // Receiver backpressure
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each taken pixel with the oldest expectation
  always @(posedge clk) begin : pixel_check
    pixel_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel item: x=%0d y=%0d", m_axis_tdata[CB-1:0],
               m_axis_tdata[2*CB-1:CB]);
        mismatch_cnt++;
      end else begin
        want = pending_pixels.pop_front();
        if (m_axis_tdata[CB-1:0] !== want.x) begin
          $error("pixel_x: expected %0d, got %0d", want.x, m_axis_tdata[CB-1:0]);
          mismatch_cnt++;
        end
        if (m_axis_tdata[2*CB-1:CB] !== want.y) begin
          $error("pixel_y: expected %0d, got %0d", want.y, m_axis_tdata[2*CB-1:CB]);
          mismatch_cnt++;
        end
        if (m_axis_tdata[2*CB+CLR_W-1:2*CB] !== want.color) begin
          $error("pixel_color: expected %06h, got %06h", want.color,
                 m_axis_tdata[2*CB+CLR_W-1:2*CB]);
          mismatch_cnt++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_pixel: expected %0b, got %0b", want.last, m_axis_tlast);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Main sequence
  initial begin : stimulus
    pixel_t typed;
    int     i;
    logic [CLR_W-1:0] colors [4];
    int     idle_s [4];
    int     idle_r [4];

    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = lr_pkg::MODE_LOAD;
    m_axis_tready  = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    mismatch_cnt   = 0;
    taken_items    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    w_busy    = 1'b0;
    w_flat    = 1'b0;
    w_col     = '0;
    w_row     = '0;
    w_col_err = '0;
    w_row_err = '0;
    w_col_d   = '0;
    w_row_d   = '0;
    w_col_dir = lr_pkg::DIR_NONE;
    w_row_dir = lr_pkg::DIR_NONE;
    w_major   = '0;
    w_left    = '0;
    w_color   = lr_pkg::FG_COLOR_RST;

    colors = '{24'h000000, 24'hFFFFFF, 24'($urandom), 24'($urandom)};
    idle_s = '{0, 67, 0, 19};
    idle_r = '{0, 0, 67, 19};

    // Directed rows: mode, endpoints, check kind, typed pixel
    plan = '{
      '{ST, 10'd0,    10'd0,    10'd0,    10'd0,    EXP_NONE,  10'd0,    10'd0,    1'b0},
      '{LD, 10'd5,    10'd7,    10'd8,    10'd7,    EXP_NONE,  10'd0,    10'd0,    1'b0},
      '{ST, 10'd0,    10'd0,    10'd0,    10'd0,    EXP_PIXEL, 10'd5,    10'd7,    1'b0},
      '{ST, 10'd1023, 10'd1023, 10'd1023, 10'd1023, EXP_PIXEL, 10'd6,    10'd7,    1'b0},
      '{ST, 10'd0,    10'd0,    10'd0,    10'd0,    EXP_PIXEL, 10'd7,    10'd7,    1'b1},
      '{ST, 10'd0,    10'd0,    10'd0,    10'd0,    EXP_NONE,  10'd0,    10'd0,    1'b0},
      '{LD, 10'd9,    10'd3,    10'd9,    10'd3,    EXP_NONE,  10'd0,    10'd0,    1'b0},
      '{ST, 10'd0,    10'd0,    10'd0,    10'd0,    EXP_NONE,  10'd0,    10'd0,    1'b0},
      '{LD, 10'd1023, 10'd0,    10'd0,    10'd0,    EXP_NONE,  10'd0,    10'd0,    1'b0},
      '{ST, 10'd0,    10'd0,    10'd0,    10'd0,    EXP_NONE,  10'd0,    10'd0,    1'b0},
      '{LD, 10'd1022, 10'd1023, 10'd1023, 10'd1023, EXP_NONE,  10'd0,    10'd0,    1'b0},
      '{ST, 10'd0,    10'd0,    10'd0,    10'd0,    EXP_PIXEL, 10'd1022, 10'd1023, 1'b1},
      '{LD, 10'd0,    10'd0,    10'd0,    10'd2,    EXP_NONE,  10'd0,    10'd0,    1'b0},
      '{ST, 10'd0,    10'd0,    10'd0,    10'd0,    EXP_MODEL, 10'd0,    10'd0,    1'b0},
      '{ST, 10'd0,    10'd0,    10'd0,    10'd0,    EXP_MODEL, 10'd0,    10'd0,    1'b0},
      '{ST, 10'd0,    10'd0,    10'd0,    10'd0,    EXP_MODEL, 10'd0,    10'd0,    1'b0},
      '{ST, 10'd0,    10'd0,    10'd0,    10'd0,    EXP_MODEL, 10'd0,    10'd0,    1'b0},
      '{ST, 10'd0,    10'd0,    10'd0,    10'd0,    EXP_NONE,  10'd0,    10'd0,    1'b0},
      '{LD, 10'd1023, 10'd1023, 10'd1020, 10'd1021, EXP_NONE,  10'd0,    10'd0,    1'b0},
      '{ST, 10'd0,    10'd0,    10'd0,    10'd0,    EXP_MODEL, 10'd0,    10'd0,    1'b0},
      '{ST, 10'd0,    10'd0,    10'd0,    10'd0,    EXP_MODEL, 10'd0,    10'd0,    1'b0},
      // drop the line in progress
      '{LD, 10'd0,    10'd1023, 10'd1023, 10'd0,    EXP_NONE,  10'd0,    10'd0,    1'b0},
      '{ST, 10'd0,    10'd0,    10'd0,    10'd0,    EXP_MODEL, 10'd0,    10'd0,    1'b0},
      '{ST, 10'd0,    10'd0,    10'd0,    10'd0,    EXP_MODEL, 10'd0,    10'd0,    1'b0},
      '{LD, 10'd3,    10'd0,    10'd0,    10'd1,    EXP_NONE,  10'd0,    10'd0,    1'b0}
    };

    // Reset
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, reset color
    for (i = 0; i < 25; i++) begin
      typed       = '0;
      typed.x     = plan[i].ex;
      typed.y     = plan[i].ey;
      typed.last  = plan[i].elast;
      send_item(plan[i].mode, plan[i].xa, plan[i].ya, plan[i].xb, plan[i].yb,
                plan[i].chk, typed);
    end

    // Random phases, each with its own color and idling mix
    for (i = 0; i < 4; i++) begin
      drain();
      write_color(colors[i]);
      send_idle_pct  = idle_s[i];
      recv_stall_pct = idle_r[i];
      run_lines(430);
    end

    // Wait for the tail and report
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
